// File: hw/rtl/lavm_pkg.sv
// shared types and constants for the look-at view matrix core
// no dependencies

package lavm_pkg;

	localparam int DW      = 32;  // input coordinates and translations, Q16.16
	localparam int CW      = 18;  // unit vector components, signed Q2.16
	localparam int NW      = 36;  // widest vector entering the normalizer
	localparam int AW      = 52;  // multiply accumulator
	localparam int MSTEP_W = 5;

	// multiply step numbers: cross for u, cross for v, the three dot products
	localparam logic [MSTEP_W-1:0] CU_LAST  = 5'd5;
	localparam logic [MSTEP_W-1:0] CV_LAST  = 5'd11;
	localparam logic [MSTEP_W-1:0] DOT_LAST = 5'd20;

	localparam logic signed [CW-1:0] ONE_Q16 = 18'sd65536;

	typedef enum logic [1:0] {
		SEL_UP   = 2'd0,
		SEL_DIFF = 2'd1,
		SEL_TMP  = 2'd2
	} norm_sel_t;

	typedef struct packed {
		logic               in_take;
		logic               norm_start;
		norm_sel_t          norm_sel;
		logic               cap_sup;
		logic               cap_n;
		logic               cap_u;
		logic               mul_go;
		logic [MSTEP_W-1:0] mstep;
		logic               out_load;
	} lavm_cmd_t;

	typedef struct packed {
		logic norm_done;
		logic out_full;
	} lavm_sts_t;

endpackage

// File: hw/rtl/lavm_norm.sv
// iterative vector normalizer: alignment shift, sum of squares, bitwise square root,
// three restoring divisions; depends on lavm_pkg

module lavm_norm import lavm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] vec [3],
	output logic                 done,
	output logic signed [CW-1:0] res [3]
);

	typedef enum logic [5:0] {
		N_IDLE  = 6'b000001,
		N_SHIFT = 6'b000010,
		N_SQ    = 6'b000100,
		N_SQRT  = 6'b001000,
		N_DIV   = 6'b010000,
		N_DONE  = 6'b100000
	} nstate_t;

	nstate_t       state_q;
	logic [NW-1:0] m_q [3];
	logic [2:0]    neg_q;
	logic [1:0]    sq_cnt_q;
	logic [59:0]   prod_s1;
	logic [61:0]   sum_q;
	logic [61:0]   s_q;
	logic [62:0]   root_q;
	logic [62:0]   bit_q;
	logic [1:0]    ci_q;
	logic [4:0]    dcnt_q;
	logic [31:0]   rem_q;
	logic [16:0]   nlo_q;
	logic [16:0]   quo_q;

	logic [NW-1:0] mx;
	logic [29:0]   sq_op;
	logic [63:0]   trial;
	logic [46:0]   num;
	logic [32:0]   rem_sh;
	logic          qbit;
	logic [32:0]   rem_nx;
	logic [16:0]   quo_nx;

	always_comb begin
		mx = m_q[0];
		if (m_q[1] > mx) mx = m_q[1];
		if (m_q[2] > mx) mx = m_q[2];
	end

	always_comb begin
		case (sq_cnt_q)
			2'd0:    sq_op = m_q[0][29:0];
			2'd1:    sq_op = m_q[1][29:0];
			default: sq_op = m_q[2][29:0];
		endcase
	end

	assign trial = {1'b0, root_q} + {1'b0, bit_q};

	// numerator m * 2^16 + len / 2, len is the root below 2^31
	assign num    = {1'b0, m_q[ci_q][29:0], 16'd0} + {16'd0, root_q[31:1]};
	assign rem_sh = {rem_q, nlo_q[16]};
	assign qbit   = rem_sh >= {1'b0, root_q[31:0]};
	assign rem_nx = qbit ? rem_sh - {1'b0, root_q[31:0]} : rem_sh;
	assign quo_nx = {quo_q[15:0], qbit};

	assign done = state_q == N_DONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= N_IDLE;
			sq_cnt_q <= '0;
			ci_q     <= '0;
			dcnt_q   <= '0;
		end else begin
			unique case (state_q)
				N_IDLE: begin
					if (start) state_q <= N_SHIFT;
				end
				N_SHIFT: begin
					if (mx == '0) state_q <= N_DONE;
					else if (mx[NW-1:30] == '0 && mx[29]) begin
						state_q  <= N_SQ;
						sq_cnt_q <= '0;
					end
				end
				N_SQ: begin
					sq_cnt_q <= sq_cnt_q + 2'd1;
					if (sq_cnt_q == 2'd3) state_q <= N_SQRT;
				end
				N_SQRT: begin
					if (bit_q == '0) begin
						state_q <= N_DIV;
						ci_q    <= '0;
						dcnt_q  <= '0;
					end
				end
				N_DIV: begin
					if (dcnt_q == 5'd17) begin
						dcnt_q <= '0;
						ci_q   <= ci_q + 2'd1;
						if (ci_q == 2'd2) state_q <= N_DONE;
					end else begin
						dcnt_q <= dcnt_q + 5'd1;
					end
				end
				N_DONE: state_q <= N_IDLE;
				default: state_q <= N_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			N_IDLE: begin
				if (start) begin
					for (int i = 0; i < 3; i++) begin
						neg_q[i] <= vec[i][NW-1];
						m_q[i]   <= vec[i][NW-1] ? NW'(~vec[i] + 1'b1) : NW'(vec[i]);
					end
				end
			end
			N_SHIFT: begin
				if (mx == '0) begin
					for (int i = 0; i < 3; i++) res[i] <= '0;
				end else if (mx[NW-1:30] != '0) begin
					for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
				end else if (!mx[29]) begin
					for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
				end
				sum_q <= '0;
			end
			N_SQ: begin
				if (sq_cnt_q != 2'd3) prod_s1 <= sq_op * sq_op;
				if (sq_cnt_q != 2'd0) sum_q <= sum_q + {2'd0, prod_s1};
				if (sq_cnt_q == 2'd3) begin
					s_q    <= sum_q + {2'd0, prod_s1};
					root_q <= '0;
					bit_q  <= 63'd1 << 62;
				end
			end
			N_SQRT: begin
				if (bit_q != '0) begin
					if ({2'd0, s_q} >= trial) begin
						s_q    <= 62'(({2'd0, s_q} - trial));
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
			end
			N_DIV: begin
				if (dcnt_q == 5'd0) begin
					rem_q <= {2'd0, num[46:17]};
					nlo_q <= num[16:0];
					quo_q <= '0;
				end else begin
					rem_q <= rem_nx[31:0];
					nlo_q <= {nlo_q[15:0], 1'b0};
					quo_q <= quo_nx;
					if (dcnt_q == 5'd17) begin
						res[ci_q] <= neg_q[ci_q] ? -$signed({1'b0, quo_nx})
						                         : $signed({1'b0, quo_nx});
					end
				end
			end
			default: ;
		endcase
	end

endmodule

// File: hw/rtl/lavm_ctrl.sv
// controller state machine: sequences normalizations, multiply steps and output load
// depends on lavm_pkg

module lavm_ctrl import lavm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_load,
	input  lavm_sts_t sts,
	output lavm_cmd_t cmd
);

	typedef enum logic [10:0] {
		C_IDLE    = 11'b00000000001,
		C_UP_GO   = 11'b00000000010,
		C_UP_WAIT = 11'b00000000100,
		C_N_GO    = 11'b00000001000,
		C_N_WAIT  = 11'b00000010000,
		C_CU_MUL  = 11'b00000100000,
		C_U_GO    = 11'b00001000000,
		C_U_WAIT  = 11'b00010000000,
		C_CV_MUL  = 11'b00100000000,
		C_DOT_MUL = 11'b01000000000,
		C_OUT     = 11'b10000000000
	} cstate_t;

	cstate_t            state_q, state_d;
	logic [MSTEP_W-1:0] mstep_q, mstep_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			mstep_q <= '0;
		end else begin
			state_q <= state_d;
			mstep_q <= mstep_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mstep_d   = mstep_q;
		cmd       = '0;
		cmd.mstep = mstep_q;
		unique case (state_q)
			C_IDLE: begin
				cmd.in_take = in_valid;
				if (in_valid) begin
					mstep_d = '0;
					state_d = in_load ? C_UP_GO : C_N_GO;
				end
			end
			C_UP_GO: begin
				cmd.norm_start = 1'b1;
				cmd.norm_sel   = SEL_UP;
				state_d        = C_UP_WAIT;
			end
			C_UP_WAIT: begin
				cmd.cap_sup = sts.norm_done;
				if (sts.norm_done) state_d = C_N_GO;
			end
			C_N_GO: begin
				cmd.norm_start = 1'b1;
				cmd.norm_sel   = SEL_DIFF;
				state_d        = C_N_WAIT;
			end
			C_N_WAIT: begin
				cmd.cap_n = sts.norm_done;
				if (sts.norm_done) state_d = C_CU_MUL;
			end
			// after the last step this state pauses with no multiply, so the accumulator settles before u is normalized
			C_CU_MUL: begin
				if (mstep_q <= CU_LAST) begin
					cmd.mul_go = 1'b1;
					mstep_d    = mstep_q + 1'b1;
				end else begin
					state_d = C_U_GO;
				end
			end
			C_U_GO: begin
				cmd.norm_start = 1'b1;
				cmd.norm_sel   = SEL_TMP;
				state_d        = C_U_WAIT;
			end
			C_U_WAIT: begin
				cmd.cap_u = sts.norm_done;
				if (sts.norm_done) state_d = C_CV_MUL;
			end
			C_CV_MUL: begin
				if (mstep_q <= CV_LAST) begin
					cmd.mul_go = 1'b1;
					mstep_d    = mstep_q + 1'b1;
				end else begin
					state_d = C_DOT_MUL;
				end
			end
			C_DOT_MUL: begin
				if (mstep_q <= DOT_LAST) begin
					cmd.mul_go = 1'b1;
					mstep_d    = mstep_q + 1'b1;
				end else begin
					state_d = C_OUT;
				end
			end
			C_OUT: begin
				if (!sts.out_full) begin
					cmd.out_load = 1'b1;
					state_d      = C_IDLE;
				end
			end
			default: state_d = C_IDLE;
		endcase
	end

endmodule

// File: hw/rtl/lavm_dp.sv
// datapath: input registers, stored up vector, shared multiplier and accumulator,
// output register; depends on lavm_pkg and lavm_norm

module lavm_dp import lavm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  lavm_cmd_t    cmd,
	output lavm_sts_t    sts,
	input  logic [287:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [263:0] out_data
);

	logic signed [DW-1:0] eye_q [3];
	logic signed [DW:0]   diff_q [3];
	logic signed [DW-1:0] upin_q [3];
	logic signed [CW-1:0] sup_q [3];
	logic signed [CW-1:0] n_q [3];
	logic signed [CW-1:0] u_q [3];
	logic signed [NW-1:0] tmp_q [3];
	logic signed [DW-1:0] shift_q [3];
	logic signed [AW-1:0] acc_q;
	logic signed [63:0]   prod_s1;
	logic                 mul_v_s1;
	logic [MSTEP_W-1:0]   mstep_s1;
	logic                 out_valid_q;

	logic signed [NW-1:0] norm_in [3];
	logic signed [CW-1:0] norm_res [3];
	logic                 norm_done;
	logic signed [DW-1:0] a_op, b_op;
	logic signed [AW-1:0] pterm, acc_next, vr, nd, sr;
	logic signed [CW-1:0] v_val;
	logic signed [DW-1:0] sh_val;

	function automatic logic signed [DW-1:0] sx(input logic signed [CW-1:0] x);
		return {{(DW-CW){x[CW-1]}}, x};
	endfunction

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			case (cmd.norm_sel)
				SEL_UP:   norm_in[i] = {{(NW-DW){upin_q[i][DW-1]}}, upin_q[i]};
				SEL_DIFF: norm_in[i] = {{(NW-DW-1){diff_q[i][DW]}}, diff_q[i]};
				default:  norm_in[i] = tmp_q[i];
			endcase
		end
	end

	lavm_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.norm_start),
		.vec    (norm_in),
		.done   (norm_done),
		.res    (norm_res)
	);

	// operand pairs: stored up x n, n x u, then u, v and n against the eye
	always_comb begin
		unique case (cmd.mstep)
			5'd0:    begin a_op = sx(sup_q[1]); b_op = sx(n_q[2]); end
			5'd1:    begin a_op = sx(sup_q[2]); b_op = sx(n_q[1]); end
			5'd2:    begin a_op = sx(sup_q[2]); b_op = sx(n_q[0]); end
			5'd3:    begin a_op = sx(sup_q[0]); b_op = sx(n_q[2]); end
			5'd4:    begin a_op = sx(sup_q[0]); b_op = sx(n_q[1]); end
			5'd5:    begin a_op = sx(sup_q[1]); b_op = sx(n_q[0]); end
			5'd6:    begin a_op = sx(n_q[1]);   b_op = sx(u_q[2]); end
			5'd7:    begin a_op = sx(n_q[2]);   b_op = sx(u_q[1]); end
			5'd8:    begin a_op = sx(n_q[2]);   b_op = sx(u_q[0]); end
			5'd9:    begin a_op = sx(n_q[0]);   b_op = sx(u_q[2]); end
			5'd10:   begin a_op = sx(n_q[0]);   b_op = sx(u_q[1]); end
			5'd11:   begin a_op = sx(n_q[1]);   b_op = sx(u_q[0]); end
			5'd12:   begin a_op = sx(u_q[0]);   b_op = eye_q[0]; end
			5'd13:   begin a_op = sx(u_q[1]);   b_op = eye_q[1]; end
			5'd14:   begin a_op = sx(u_q[2]);   b_op = eye_q[2]; end
			5'd15:   begin a_op = sx(sup_q[0]); b_op = eye_q[0]; end
			5'd16:   begin a_op = sx(sup_q[1]); b_op = eye_q[1]; end
			5'd17:   begin a_op = sx(sup_q[2]); b_op = eye_q[2]; end
			5'd18:   begin a_op = sx(n_q[0]);   b_op = eye_q[0]; end
			5'd19:   begin a_op = sx(n_q[1]);   b_op = eye_q[1]; end
			default: begin a_op = sx(n_q[2]);   b_op = eye_q[2]; end
		endcase
	end

	assign pterm = $signed(prod_s1[AW-1:0]);

	always_comb begin
		case (mstep_s1) inside
			5'd0, 5'd2, 5'd4, 5'd6, 5'd8, 5'd10, 5'd12, 5'd15, 5'd18: acc_next = pterm;
			5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd11:                    acc_next = acc_q - pterm;
			default:                                                 acc_next = acc_q + pterm;
		endcase
	end

	// round to Q16.16 with half toward +inf, then clamp or saturate
	always_comb begin
		vr = (acc_next + 52'sd32768) >>> 16;
		if (vr > 52'sd65536) v_val = ONE_Q16;
		else if (vr < -52'sd65536) v_val = -ONE_Q16;
		else v_val = vr[CW-1:0];
		nd = -acc_next;
		sr = (nd + 52'sd32768) >>> 16;
		if (sr > 52'sd2147483647) sh_val = 32'sh7fffffff;
		else if (sr < -52'sd2147483648) sh_val = 32'sh80000000;
		else sh_val = sr[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sup_q[0]    <= '0;
			sup_q[1]    <= ONE_Q16;
			sup_q[2]    <= '0;
			mul_v_s1    <= 1'b0;
			mstep_s1    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			mul_v_s1 <= cmd.mul_go;
			if (cmd.mul_go) mstep_s1 <= cmd.mstep;
			if (cmd.cap_sup) begin
				for (int i = 0; i < 3; i++) sup_q[i] <= norm_res[i];
			end
			if (mul_v_s1) begin
				case (mstep_s1)
					5'd7:    sup_q[0] <= v_val;
					5'd9:    sup_q[1] <= v_val;
					5'd11:   sup_q[2] <= v_val;
					default: ;
				endcase
			end
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_take) begin
			for (int i = 0; i < 3; i++) begin
				eye_q[i]  <= in_data[i*DW +: DW];
				diff_q[i] <= {in_data[i*DW+DW-1], in_data[i*DW +: DW]}
				           - {in_data[(i+3)*DW+DW-1], in_data[(i+3)*DW +: DW]};
				upin_q[i] <= in_data[(i+6)*DW +: DW];
			end
		end
		if (cmd.cap_n) begin
			for (int i = 0; i < 3; i++) n_q[i] <= norm_res[i];
		end
		if (cmd.cap_u) begin
			for (int i = 0; i < 3; i++) u_q[i] <= norm_res[i];
		end
		if (cmd.mul_go) prod_s1 <= a_op * b_op;
		if (mul_v_s1) begin
			acc_q <= acc_next;
			case (mstep_s1)
				5'd1:    tmp_q[0]   <= acc_next[NW-1:0];
				5'd3:    tmp_q[1]   <= acc_next[NW-1:0];
				5'd5:    tmp_q[2]   <= acc_next[NW-1:0];
				5'd14:   shift_q[0] <= sh_val;
				5'd17:   shift_q[1] <= sh_val;
				5'd20:   shift_q[2] <= sh_val;
				default: ;
			endcase
		end
		if (cmd.out_load) begin
			for (int i = 0; i < 3; i++) begin
				out_data[(3*i)*CW +: CW]   <= u_q[i];
				out_data[(3*i+1)*CW +: CW] <= sup_q[i];
				out_data[(3*i+2)*CW +: CW] <= n_q[i];
				out_data[9*CW + i*DW +: DW] <= shift_q[i];
			end
			out_data[263:258] <= '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign sts.norm_done = norm_done;
	assign sts.out_full  = out_valid_q & ~out_ready;

endmodule

// File: hw/rtl/look_at_view_matrix_core.sv
// look-at view matrix core, top level
// depends on lavm_pkg, lavm_ctrl, lavm_dp (which holds lavm_norm)
//
// one item on the s_ channel gives eye, target and up vectors plus a load flag in
// s_tuser; the m_ channel returns u, v, n and the three eye translations in Q16.16.
// the stored up vector is replaced by v after every item and by the normalized
// input up vector first when the load flag is set.
// one item is worked on at a time: s_tready is high only while the block is idle.
// the time from transfer in to m_tvalid is set mostly by the shared normalizer (one bit per
// cycle in the alignment shifter, 32 square root steps, three 17-step divisions; a zero
// vector skips the root and divisions), run two or three times per item, plus the
// shared 32x32 multiplier for the cross and dot products.
// the result sits in an output register; if the receiver stalls, the next item is
// still taken and computed, and it waits only at its own output load.
// reset clears all handshakes and sets the stored up vector to (0, 1.0, 0).

module look_at_view_matrix_core import lavm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
	input  logic [287:0] s_tdata,
	// load_up
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// right_x, up_out_x, back_x, right_y, up_out_y, back_y, right_z, up_out_z, back_z,
	// shift_x, shift_y, shift_z, zero pad
	output logic [263:0] m_tdata
);

	lavm_cmd_t cmd;
	lavm_sts_t sts;

	lavm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_load  (s_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	lavm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

	assign s_tready = cmd.in_take;

endmodule

// File: tb/sv/tb_look_at_view_matrix_core.sv
// self-checking testbench for look_at_view_matrix_core
// depends on lavm_pkg and the core rtl; predicts each view matrix in fixed point

`timescale 1ns / 1ps

module tb_look_at_view_matrix_core;
	import lavm_pkg::*;

	typedef struct {
		logic signed [31:0] eye [3];
		logic signed [31:0] tgt [3];
		logic signed [31:0] upv [3];
		logic               load;
	} camera_t;

	typedef struct {
		logic signed [17:0] u [3];
		logic signed [17:0] v [3];
		logic signed [17:0] n [3];
		logic signed [31:0] sh [3];
	} view_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [287:0] s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [263:0] m_tdata;

	look_at_view_matrix_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	view_t       view_q [$];
	longint      cam_up [3];
	int          n_sent, n_views, n_errors, n_loads;
	bit          hold_off;

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	function automatic longint unsigned sqrt64(longint unsigned s);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > s) b >>= 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	// floor((x + 2^15) / 2^16)
	function automatic longint rnd16(longint x);
		longint t;
		t = x + 32768;
		if (t >= 0) return longint'(longint'(longint'(unsigned'(t)) >> 16));
		return -longint'((longint'(unsigned'(-t)) + 65535) >> 16);
	endfunction

	function automatic void unit_vec(input longint a [3], output longint r [3]);
		longint unsigned m [3];
		longint unsigned mx, sum, len;
		bit ng [3];
		mx = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			ng[i] = a[i] < 0;
			m[i] = ng[i] ? -a[i] : a[i];
			if (m[i] > mx) mx = m[i];
		end
		if (mx == 0) begin
			r = '{0, 0, 0};
			return;
		end
		while (mx >= (64'd1 << 30)) begin
			mx >>= 1;
			for (int i = 0; i < 3; i++) m[i] >>= 1;
		end
		while (mx < (64'd1 << 29)) begin
			mx <<= 1;
			for (int i = 0; i < 3; i++) m[i] <<= 1;
		end
		for (int i = 0; i < 3; i++) sum += m[i] * m[i];
		len = sqrt64(sum);
		for (int i = 0; i < 3; i++) begin
			longint q;
			q = longint'((m[i] * 65536 + len / 2) / len);
			r[i] = ng[i] ? -q : q;
		end
	endfunction

	function automatic void cross3(input longint a [3], input longint b [3],
			output longint r [3]);
		r[0] = a[1] * b[2] - a[2] * b[1];
		r[1] = a[2] * b[0] - a[0] * b[2];
		r[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	function automatic longint eye_shift(longint a [3], longint e [3]);
		longint d;
		d = rnd16(-(a[0] * e[0] + a[1] * e[1] + a[2] * e[2]));
		if (d > 64'sd2147483647) d = 64'sd2147483647;
		if (d < -64'sd2147483648) d = -64'sd2147483648;
		return d;
	endfunction

	function automatic view_t predict_view(camera_t c);
		longint e [3], d [3], n [3], u [3], t [3], w [3], up [3];
		view_t r;
		for (int i = 0; i < 3; i++) begin
			e[i] = longint'(c.eye[i]);
			d[i] = longint'(c.eye[i]) - longint'(c.tgt[i]);
			up[i] = longint'(c.upv[i]);
		end
		if (c.load) unit_vec(up, cam_up);
		unit_vec(d, n);
		cross3(cam_up, n, t);
		unit_vec(t, u);
		cross3(n, u, t);
		for (int i = 0; i < 3; i++) begin
			w[i] = rnd16(t[i]);
			if (w[i] > 65536) w[i] = 65536;
			if (w[i] < -65536) w[i] = -65536;
			cam_up[i] = w[i];
			r.u[i] = 18'(u[i]);
			r.v[i] = 18'(w[i]);
			r.n[i] = 18'(n[i]);
		end
		r.sh[0] = 32'(eye_shift(u, e));
		r.sh[1] = 32'(eye_shift(w, e));
		r.sh[2] = 32'(eye_shift(n, e));
		return r;
	endfunction

	task automatic send_camera(camera_t c);
		logic [287:0] d;
		for (int i = 0; i < 3; i++) begin
			d[32*i +: 32]       = c.eye[i];
			d[96 + 32*i +: 32]  = c.tgt[i];
			d[192 + 32*i +: 32] = c.upv[i];
		end
		// each item starts on its own falling edge, after the previous one dropped tvalid
		@(negedge clk);
		s_tdata  <= d;
		s_tuser  <= c.load;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		view_q.push_back(predict_view(c));
		n_sent++;
		if (c.load) n_loads++;
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// sender pause between items: bursts with random gaps
	int burst_left;
	task automatic pace();
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 300)) @(negedge clk);
		end
		burst_left--;
	endtask

	function automatic logic signed [31:0] rnd_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			2: return $signed($urandom_range(0, 131072)) - 65536;
			3: return $signed($urandom) >>> $urandom_range(0, 31);
			default: return $signed($urandom_range(0, 2000000)) - 1000000;
		endcase
	endfunction

	function automatic camera_t rnd_camera(bit load);
		camera_t c;
		for (int i = 0; i < 3; i++) begin
			c.eye[i] = rnd_coord();
			c.tgt[i] = ($urandom_range(0, 15) == 0) ? c.eye[i] : rnd_coord();
			c.upv[i] = rnd_coord();
		end
		if ($urandom_range(0, 19) == 0) c.upv = '{0, 0, 0};
		c.load = load;
		return c;
	endfunction

	function automatic camera_t mk(int ex, int ey, int ez, int tx, int ty, int tz,
			int ux, int uy, int uz, bit ld);
		camera_t c;
		c.eye = '{ex, ey, ez};
		c.tgt = '{tx, ty, tz};
		c.upv = '{ux, uy, uz};
		c.load = ld;
		return c;
	endfunction

	task automatic test_directed();
		localparam int ONE = 65536;
		localparam int MX = 32'h7fffffff;
		localparam int MN = 32'h80000000;
		send_camera(mk(0, 0, 5*ONE, 0, 0, 0, 0, 0, 0, 0));        // default up
		send_camera(mk(0, 0, 5*ONE, 0, 0, 0, 0, ONE, 0, 1));
		send_camera(mk(3*ONE, 2*ONE, ONE, 3*ONE, 2*ONE, ONE, 0, ONE, 0, 1)); // eye on target
		send_camera(mk(0, 5*ONE, 0, 0, 0, 0, 0, ONE, 0, 1));      // up along view
		send_camera(mk(ONE, 2*ONE, 3*ONE, 0, 0, 0, 0, 0, 0, 0));  // stays degenerate
		send_camera(mk(ONE, 2*ONE, 3*ONE, 0, 0, 0, 0, 0, 0, 1));  // zero up loaded
		send_camera(mk(MX, MX, MX, MN, MN, MN, MX, MN, MX, 1));
		send_camera(mk(MN, MN, MN, MX, MX, MX, MN, MX, MN, 1));
		send_camera(mk(MX, MN, MX, 0, 0, 0, 1, 1, 1, 1));
		send_camera(mk(MN, MX, MN, 0, 0, 0, -1, 0, 0, 1));
		send_camera(mk(1, 0, 0, 0, 0, 0, 0, 1, 0, 1));
		send_camera(mk(0, 1, 1, 0, 0, 0, MN, 0, 0, 1));
		send_camera(mk(MX, 0, MN, MN, 0, MX, 0, MX, 0, 1));
		send_camera(mk(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 0, -ONE, 1));
		send_camera(mk(7, -3, 11, 2, 5, -9, 3, 1, 0, 0));
	endtask

	task automatic test_random(int count);
		for (int k = 0; k < count; k++) begin
			pace();
			// mostly chains that keep the up vector, loads now and then
			send_camera(rnd_camera($urandom_range(0, 3) == 0));
		end
	endtask

	task automatic test_backpressure();
		hold_off = 1'b1;
		for (int k = 0; k < 6; k++) send_camera(rnd_camera($urandom_range(0, 1)));
		wait (!hold_off);
	endtask

	// receiver: stall pattern plus a long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (3000) @(negedge clk);
				hold_off = 1'b0;
			end else begin
				case ((n_views / 64) % 3)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					default: m_tready <= ($urandom_range(0, 1) == 1);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			view_t x, a;
			for (int i = 0; i < 3; i++) begin
				a.u[i]  = m_tdata[54*i +: 18];
				a.v[i]  = m_tdata[54*i + 18 +: 18];
				a.n[i]  = m_tdata[54*i + 36 +: 18];
				a.sh[i] = m_tdata[162 + 32*i +: 32];
			end
			n_views++;
			if (view_q.size() == 0) begin
				$display("%0t: result with none expected: %h", $time, m_tdata);
				n_errors++;
			end else begin
				x = view_q.pop_front();
				for (int i = 0; i < 3; i++) begin
					if (a.u[i] !== x.u[i]) begin
						$display("%0t: right[%0d] exp %0d got %0d", $time, i, x.u[i], a.u[i]);
						n_errors++;
					end
					if (a.v[i] !== x.v[i]) begin
						$display("%0t: up_out[%0d] exp %0d got %0d", $time, i, x.v[i], a.v[i]);
						n_errors++;
					end
					if (a.n[i] !== x.n[i]) begin
						$display("%0t: back[%0d] exp %0d got %0d", $time, i, x.n[i], a.n[i]);
						n_errors++;
					end
					if (a.sh[i] !== x.sh[i]) begin
						$display("%0t: shift[%0d] exp %0d got %0d", $time, i, x.sh[i], a.sh[i]);
						n_errors++;
					end
				end
			end
		end
	end

	initial begin
		#400ms;
		$display("tb_look_at_view_matrix_core: FAIL");
		$finish;
	end

	initial begin
		int spin;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		arst_n   = 1'b0;
		hold_off = 1'b0;
		n_sent = 0;
		n_views = 0;
		n_errors = 0;
		n_loads = 0;
		burst_left = 0;
		cam_up = '{0, 65536, 0};
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_backpressure();
		test_random(880);
		spin = 0;
		while (view_q.size() != 0 && spin < 200000) begin
			@(negedge clk);
			spin++;
		end
		repeat (500) @(negedge clk);
		$display("covered %0d cameras (%0d with up loaded), %0d matrices checked",
			n_sent, n_loads, n_views);
		if (n_errors == 0 && view_q.size() == 0)
			$display("tb_look_at_view_matrix_core: PASS");
		else
			$display("tb_look_at_view_matrix_core: FAIL");
		$finish;
	end

endmodule
